// ----- rtl/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Character LCD write sequencer package
// Shared types, codes and the fixed initialization command table.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int HoldW  = 20;
   localparam int PulseW = 16;
   localparam int ModeW  = 3;
   localparam int ByteW  = 8;
   localparam int CsrIdxW = 2;

   localparam int DefQueueDepth = 2;

   // Request modes.
   localparam logic [ModeW-1:0] MODE_INIT   = 3'd0;
   localparam logic [ModeW-1:0] MODE_CMD    = 3'd1;
   localparam logic [ModeW-1:0] MODE_CHAR   = 3'd2;
   localparam logic [ModeW-1:0] MODE_CURSOR = 3'd3;
   localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd4;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_FOUR_BIT   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_PULSE_HOLD = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CLEAR_HOLD = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_POWER_HOLD = 2'd3;

   // Configuration reset values.
   localparam logic              RST_FOUR_BIT   = 1'b1;
   localparam logic [PulseW-1:0] RST_PULSE_HOLD = 16'd400;
   localparam logic [HoldW-1:0]  RST_CLEAR_HOLD = 20'd15200;
   localparam logic [HoldW-1:0]  RST_POWER_HOLD = 20'd150000;

   // LCD command bytes.
   localparam logic [ByteW-1:0] LCD_FUNC4_A   = 8'h33;
   localparam logic [ByteW-1:0] LCD_FUNC4_B   = 8'h32;
   localparam logic [ByteW-1:0] LCD_FUNC4_C   = 8'h28;
   localparam logic [ByteW-1:0] LCD_FUNC8     = 8'h38;
   localparam logic [ByteW-1:0] LCD_DISP_ON   = 8'h0E;
   localparam logic [ByteW-1:0] LCD_CLEAR     = 8'h01;
   localparam logic [ByteW-1:0] LCD_ENTRY     = 8'h06;
   localparam logic [ByteW-1:0] LCD_HOME_ADDR = 8'h80;

   // Cursor address bounds (upper nibble of row one and row two).
   localparam logic [3:0] ROW1_HI = 4'h8;
   localparam logic [3:0] ROW2_HI = 4'hC;

   // Init sequence: seven command bytes, the clear sits at index four.
   localparam int InitIdxW = 3;
   localparam logic [InitIdxW-1:0] INIT_CLEAR_IDX = 3'd4;
   localparam logic [InitIdxW-1:0] INIT_LAST_IDX  = 3'd6;

   typedef enum logic {
      JOB_INIT,
      JOB_BYTE
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic             rs;
      logic [ByteW-1:0] data_byte;
      logic             use_clear;
   } job_type;

   typedef struct packed {
      logic              four_bit;
      logic [PulseW-1:0] pulse_hold;
      logic [HoldW-1:0]  clear_hold;
      logic [HoldW-1:0]  power_hold;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_POWER,
      BK_INIT,
      BK_BYTE
   } bk_state_type;

   function automatic logic [ByteW-1:0] init_byte(input logic [InitIdxW-1:0] idx,
                                                  input logic four_bit);
      logic [ByteW-1:0] b;
      case (idx)
         3'd0:    b = four_bit ? LCD_FUNC4_A : LCD_FUNC8;
         3'd1:    b = four_bit ? LCD_FUNC4_B : LCD_FUNC8;
         3'd2:    b = four_bit ? LCD_FUNC4_C : LCD_FUNC8;
         3'd3:    b = LCD_DISP_ON;
         3'd4:    b = LCD_CLEAR;
         3'd5:    b = LCD_ENTRY;
         default: b = LCD_HOME_ADDR;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/clcd_if.sv -----
// ----------------------------------------------------------------------------
// Character LCD channel interfaces
// Valid/ready channels for requests and bus phases.
// ----------------------------------------------------------------------------
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface clcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        rs_level;
   logic        strobe_res;
   logic [7:0]  data_lines;
   logic [19:0] hold_time;
   logic        last;

   modport source (output valid, output rs_level, output strobe_res, output data_lines,
                   output hold_time, output last, input ready);
   modport sink   (input valid, input rs_level, input strobe_res, input data_lines,
                   input hold_time, input last, output ready);
endinterface

// ----- rtl/clcd_front.sv -----
// ----------------------------------------------------------------------------
// Character LCD request front end
// Accepts requests, drops invalid ones and turns the rest into queue jobs.
// ----------------------------------------------------------------------------
module clcd_front (
   clcd_req_if.sink         req,
   output logic             push_valid,
   output clcd_pkg::job_type push_job,
   input  logic             push_ready
);
   import clcd_pkg::*;

   logic keep;

   assign req.ready = push_ready;

   always_comb begin
      keep               = 1'b0;
      push_job.kind      = JOB_BYTE;
      push_job.rs        = 1'b0;
      push_job.data_byte = req.value;
      push_job.use_clear = 1'b0;
      unique case (req.mode)
         MODE_INIT: begin
            keep          = 1'b1;
            push_job.kind = JOB_INIT;
         end
         MODE_CMD: begin
            keep = 1'b1;
         end
         MODE_CHAR: begin
            keep        = 1'b1;
            push_job.rs = 1'b1;
         end
         MODE_CURSOR: begin
            // Only row one or row two, columns 0 to 15, reach the bus.
            keep = (req.value[7:4] == ROW1_HI) || (req.value[7:4] == ROW2_HI);
         end
         MODE_CLEAR: begin
            keep               = 1'b1;
            push_job.data_byte = LCD_CLEAR;
            push_job.use_clear = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // A dropped request is still a transfer; it simply never enters the queue.
   assign push_valid = req.valid && keep;

endmodule

// ----- rtl/clcd_queue.sv -----
// ----------------------------------------------------------------------------
// Character LCD job queue
// Small FIFO that decouples request intake from phase generation.
// ----------------------------------------------------------------------------
module clcd_queue #(
   parameter int Depth = clcd_pkg::DefQueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  clcd_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output clcd_pkg::job_type pop_job,
   input  logic              pop_en
);
   import clcd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] Full    = CntW'(Depth);

   job_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_en && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/clcd_back.sv -----
// ----------------------------------------------------------------------------
// Character LCD phase sequencer
// Expands queued jobs into bus phases, one per cycle while rsp is not stalled, into an output register.
// ----------------------------------------------------------------------------
module clcd_back (
   input  logic              clock,
   input  logic              reset,
   input  clcd_pkg::cfg_type cfg,
   input  logic              pop_valid,
   input  clcd_pkg::job_type pop_job,
   output logic              pop_en,
   clcd_rsp_if.source        rsp
);
   import clcd_pkg::*;

   bk_state_type        state_ff, state_in;
   job_type             job_ff, job_in;
   logic [InitIdxW-1:0] idx_ff, idx_in;
   logic                nib_ff, nib_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_rs_ff, out_strobe_ff, out_last_ff;
   logic [ByteW-1:0] out_data_ff;
   logic [HoldW-1:0] out_hold_ff;

   logic             out_free, adv;
   logic [ByteW-1:0] cur_byte;
   logic             cur_clear;
   logic             ph_rs, ph_strobe, ph_last;
   logic [ByteW-1:0] ph_data;
   logic [HoldW-1:0] ph_hold;

   assign out_free = !out_valid_ff || rsp.ready;
   assign adv      = (state_ff != BK_IDLE) && out_free;
   assign pop_en   = (state_ff == BK_IDLE);

   assign cur_byte  = (state_ff == BK_INIT) ? init_byte(idx_ff, cfg.four_bit) : job_ff.data_byte;
   assign cur_clear = (state_ff == BK_INIT) ? (idx_ff == INIT_CLEAR_IDX) : job_ff.use_clear;

   // Phase outputs.
   always_comb begin
      ph_rs     = 1'b0;
      ph_strobe = 1'b1;
      ph_data   = '0;
      ph_hold   = '0;
      ph_last   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            ph_strobe = 1'b0;
         end
         BK_POWER: begin
            ph_strobe = 1'b0;
            ph_hold   = cfg.power_hold;
         end
         BK_INIT, BK_BYTE: begin
            ph_rs = (state_ff == BK_BYTE) ? job_ff.rs : 1'b0;
            if (cfg.four_bit) begin
               ph_data = {4'b0, (nib_ff ? cur_byte[3:0] : cur_byte[7:4])};
            end else begin
               ph_data = cur_byte;
            end
            ph_hold = cur_clear ? cfg.clear_hold : HoldW'(cfg.pulse_hold);
            ph_last = (!cfg.four_bit || nib_ff) &&
                      ((state_ff == BK_BYTE) || (idx_ff == INIT_LAST_IDX));
         end
         default: begin
            ph_strobe = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      nib_in   = nib_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_job;
               idx_in   = '0;
               nib_in   = 1'b0;
               state_in = (pop_job.kind == JOB_INIT) ? BK_POWER : BK_BYTE;
            end
         end
         BK_POWER: begin
            if (adv) begin
               state_in = BK_INIT;
            end
         end
         BK_INIT, BK_BYTE: begin
            if (adv) begin
               if (ph_last) begin
                  state_in = BK_IDLE;
               end else if (cfg.four_bit && !nib_ff) begin
                  nib_in = 1'b1;
               end else begin
                  nib_in = 1'b0;
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         nib_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         nib_ff       <= nib_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (adv) begin
         out_rs_ff     <= ph_rs;
         out_strobe_ff <= ph_strobe;
         out_data_ff   <= ph_data;
         out_hold_ff   <= ph_hold;
         out_last_ff   <= ph_last;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.rs_level   = out_rs_ff;
   assign rsp.strobe_res = out_strobe_ff;
   assign rsp.data_lines = out_data_ff;
   assign rsp.hold_time  = out_hold_ff;
   assign rsp.last       = out_last_ff;

endmodule

// ----- rtl/char_lcd_write_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Character LCD write sequencer
// Expands requests into HD44780-style enable-strobe bus phases.
//
//   Channel  Dir  Payload                                          Transfer
//   req      in   mode[2:0], value[7:0]                            valid & ready
//   rsp      out  rs_level, strobe_res, data_lines[7:0],
//                 hold_time[19:0], last                            valid & ready
//   csr      in   csr_index[1:0], csr_wdata[19:0]                  csr_wr_en
//
// A request enters a job queue (two deep by default); the sequencer loads a
// job in its idle state, then emits one phase per cycle while rsp is not stalled:
// initialize gives 15 phases in four-bit mode and 8 in eight-bit mode, other
// requests one or two. Invalid cursor positions and unknown modes give none.
// A stalled rsp holds its phase; requests are taken while the queue has room.
// Synchronous reset restores the register defaults and empties the queue.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top #(
   parameter int QueueDepth = clcd_pkg::DefQueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   clcd_req_if.sink                     req,
   clcd_rsp_if.source                   rsp,
   input  logic                         csr_wr_en,
   input  logic [clcd_pkg::CsrIdxW-1:0] csr_index,
   input  logic [clcd_pkg::HoldW-1:0]   csr_wdata
);
   import clcd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_en;
   job_type pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FOUR_BIT:   cfg_in.four_bit   = csr_wdata[0];
            CSR_PULSE_HOLD: cfg_in.pulse_hold = csr_wdata[PulseW-1:0];
            CSR_CLEAR_HOLD: cfg_in.clear_hold = csr_wdata;
            CSR_POWER_HOLD: cfg_in.power_hold = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.four_bit   <= RST_FOUR_BIT;
         cfg_ff.pulse_hold <= RST_PULSE_HOLD;
         cfg_ff.clear_hold <= RST_CLEAR_HOLD;
         cfg_ff.power_hold <= RST_POWER_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clcd_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   clcd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_en     (pop_en)
   );

   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_en    (pop_en),
      .rsp       (rsp)
   );

endmodule
